// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/rbao_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbao_pkg;

  localparam int unsigned RELAY_COUNT_DEF = 16;
  localparam int unsigned BANK_SLOTS      = 16;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned TMO_W     = 32;
  localparam int unsigned RPT_IDX_W = 4;
  localparam int unsigned CAUSE_W   = 2;
  localparam int unsigned LIMIT_W   = 20;

  localparam logic [LIMIT_W-1:0] AUTO_OFF_MAX = LIMIT_W'(7 * 24 * 60 * 60);

  typedef enum logic [KIND_W-1:0] {
    KIND_SET      = 3'd0,
    KIND_TOGGLE   = 3'd1,
    KIND_AUTO_OFF = 3'd2,
    KIND_SYNC     = 3'd3,
    KIND_TICK     = 3'd4
  } kind_e;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_CONFIRM = 2'd0,
    CAUSE_SYNC    = 2'd1,
    CAUSE_EXPIRE  = 2'd2
  } cause_e;

  // One relay entry: auto-off limit and running countdown.
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] count;
  } slot_t;

  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== src/rbao_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rbao_cmd_if;
  import rbao_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    relay_index;
  logic                on_value;
  logic [TMO_W-1:0]    auto_off_secs;

  modport source (output valid, kind, relay_index, on_value, auto_off_secs, input ready);
  modport sink   (input valid, kind, relay_index, on_value, auto_off_secs, output ready);
endinterface

interface rbao_rpt_if;
  import rbao_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RPT_IDX_W-1:0] report_index;
  logic                 report_on;
  logic [CAUSE_W-1:0]   cause;
  logic                 last;

  modport source (output valid, report_index, report_on, cause, last, input ready);
  modport sink   (input valid, report_index, report_on, cause, last, output ready);
endinterface
`default_nettype wire

// ===== src/relay_bank_with_auto_off.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Relay bank with a per-relay auto-off countdown. Commands arrive one
// transaction at a time on cmd_i; reports leave on rpt_o through an output
// register, so a finished report may wait while the bank moves on. Limits and
// countdowns live in one single-port-read RAM, one entry per relay, read then
// written back; the relay mask sits in flip-flops. Per-entry valid bits make
// unwritten entries read as zero, so no clearing pass follows reset. Set,
// toggle and auto-off read their entry and write it back; an out-of-range
// or unused command returns straight to idle. Sync reports the active relays
// in turn; a tick reads one RAM entry per cycle unless an expiry waits on a
// stalled output. The active relay count, set by cfg_data_i, is all slots (up to 16) or at most 8.
module relay_bank_with_auto_off #(
  parameter int unsigned RELAY_COUNT = rbao_pkg::RELAY_COUNT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_data_i,
  rbao_cmd_if.sink   cmd_i,
  rbao_rpt_if.source rpt_o
);
  import rbao_pkg::*;

  localparam int unsigned SLOTS = (RELAY_COUNT < BANK_SLOTS) ? RELAY_COUNT : BANK_SLOTS;
  localparam int unsigned N8    = (SLOTS < 8) ? SLOTS : 8;
  localparam int unsigned AW    = addr_w(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SYNC,
    ST_TICK,
    ST_FLUSH
  } state_e;

  state_e               state_q, state_d;
  logic                 sixteen_q;
  logic [SLOTS-1:0]     mask_q, mask_d;
  logic [SLOTS-1:0]     vld_q;
  logic                 rd_vld_q;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 on_q, on_d;
  logic [LIMIT_W-1:0]   tmo_q, tmo_d;
  logic [AW-1:0]        i_q, i_d;
  logic                 hold_vld_q, hold_vld_d;
  logic [AW-1:0]        hold_idx_q, hold_idx_d;

  logic                 out_vld_q;
  logic [RPT_IDX_W-1:0] out_idx_q;
  logic                 out_on_q;
  cause_e               out_cause_q;
  logic                 out_last_q;

  logic                 push;
  logic [AW-1:0]        push_idx;
  logic                 push_on;
  cause_e               push_cause;
  logic                 push_last;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  slot_t                ram_wdata, ram_rdata, rd_ent;

  logic [IDX_W-1:0]     act_n, act_last;
  logic                 in_range, slot_free, at_last, now_on, expire;
  logic [LIMIT_W-1:0]   tmo_sat, cd_dec;

  rbao_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign act_n     = sixteen_q ? IDX_W'(SLOTS) : IDX_W'(N8);
  assign act_last  = act_n - IDX_W'(1);
  assign in_range  = cmd_i.relay_index < act_n;
  assign tmo_sat   = (cmd_i.auto_off_secs > TMO_W'(AUTO_OFF_MAX))
                     ? AUTO_OFF_MAX : cmd_i.auto_off_secs[LIMIT_W-1:0];
  assign slot_free = !out_vld_q || rpt_o.ready;
  assign at_last   = IDX_W'(i_q) == act_last;
  assign rd_ent    = rd_vld_q ? ram_rdata : '0;
  assign cd_dec    = rd_ent.count - LIMIT_W'(1);
  assign now_on    = (kind_q == KIND_SET) ? on_q : !mask_q[idx_q];
  assign expire    = (rd_ent.count != '0) && (cd_dec == '0) && (rd_ent.limit != '0)
                     && mask_q[i_q];

  assign cmd_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    kind_d     = kind_q;
    idx_d      = idx_q;
    on_d       = on_q;
    tmo_d      = tmo_q;
    i_d        = i_q;
    hold_vld_d = hold_vld_q;
    hold_idx_d = hold_idx_q;
    ram_re     = 1'b0;
    ram_raddr  = i_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = rd_ent;
    push       = 1'b0;
    push_idx   = idx_q;
    push_on    = 1'b0;
    push_cause = CAUSE_CONFIRM;
    push_last  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          kind_d = cmd_i.kind;
          idx_d  = cmd_i.relay_index[AW-1:0];
          on_d   = cmd_i.on_value;
          tmo_d  = tmo_sat;
          i_d    = '0;
          unique case (cmd_i.kind)
            KIND_SET, KIND_TOGGLE, KIND_AUTO_OFF: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = cmd_i.relay_index[AW-1:0];
                state_d   = ST_RMW;
              end
            end
            KIND_SYNC: state_d = ST_SYNC;
            KIND_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = ST_TICK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_RMW: begin
        if (kind_q == KIND_AUTO_OFF) begin
          if (rd_ent.limit != tmo_q) begin
            ram_we          = 1'b1;
            ram_wdata.limit = tmo_q;
            ram_wdata.count = mask_q[idx_q] ? tmo_q : '0;
          end
          state_d = ST_IDLE;
        end else if (slot_free) begin
          ram_we          = 1'b1;
          ram_wdata.count = now_on ? rd_ent.limit : '0;
          mask_d[idx_q]   = now_on;
          push            = 1'b1;
          push_on         = now_on;
          state_d         = ST_IDLE;
        end
      end

      ST_SYNC: begin
        if (slot_free) begin
          push       = 1'b1;
          push_idx   = i_q;
          push_on    = mask_q[i_q];
          push_cause = CAUSE_SYNC;
          push_last  = at_last;
          i_d        = i_q + AW'(1);
          if (at_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TICK: begin
        // An expiry waits in the hold stage until the next one, or the end of
        // the sweep, tells whether it is the last report.
        if (!(expire && hold_vld_q && !slot_free)) begin
          if (rd_ent.count != '0) begin
            ram_we          = 1'b1;
            ram_waddr       = i_q;
            ram_wdata.count = cd_dec;
          end
          if (expire) begin
            mask_d[i_q] = 1'b0;
            if (hold_vld_q) begin
              push       = 1'b1;
              push_idx   = hold_idx_q;
              push_cause = CAUSE_EXPIRE;
              push_last  = 1'b0;
            end
            hold_vld_d = 1'b1;
            hold_idx_d = i_q;
          end
          if (at_last) begin
            state_d = ST_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = i_q + AW'(1);
            i_d       = i_q + AW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_idx   = hold_idx_q;
          push_cause = CAUSE_EXPIRE;
          hold_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sixteen_q  <= 1'b1;
      mask_q     <= '0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      i_q        <= '0;
    end else begin
      state_q    <= state_d;
      mask_q     <= mask_d;
      hold_vld_q <= hold_vld_d;
      i_q        <= i_d;
      if (cfg_we_i) begin
        sixteen_q <= cfg_data_i;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (rpt_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    on_q       <= on_d;
    tmo_q      <= tmo_d;
    hold_idx_q <= hold_idx_d;
    if (push) begin
      out_idx_q   <= RPT_IDX_W'(push_idx);
      out_on_q    <= push_on;
      out_cause_q <= push_cause;
      out_last_q  <= push_last;
    end
  end

  assign rpt_o.valid        = out_vld_q;
  assign rpt_o.report_index = out_idx_q;
  assign rpt_o.report_on    = out_on_q;
  assign rpt_o.cause        = out_cause_q;
  assign rpt_o.last         = out_last_q;

  `ASSERT_AT(a_hold_in_tick, clk_i, rst_ni, hold_vld_q |-> (state_q == ST_TICK || state_q == ST_FLUSH), "expiry held outside a tick sweep")
  `ASSERT_NEVER(a_ram_same_entry, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write-back hit the same entry")
  `ASSERT_AT(a_expire_off, clk_i, rst_ni, (out_vld_q && out_cause_q == CAUSE_EXPIRE) |-> !out_on_q, "expiry report shows relay on")
  `ASSERT_AT(a_push_free, clk_i, rst_ni, push |-> slot_free, "report pushed over a waiting one")

endmodule
`default_nettype wire

// ===== src/rbao_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbao_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [rbao_pkg::addr_w(DEPTH)-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [rbao_pkg::addr_w(DEPTH)-1:0]     raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);
  import rbao_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
